// ===== hdl/avtc_pkg.sv =====
// Shared types, limits and constants of the audio volume and tone controller.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package avtc_pkg;

    // Limits of the register image
    localparam int VOLUME_FLOOR = 80;
    localparam int TREBLE_LIMIT = 5;
    localparam int BASS_LIMIT   = 10;
    localparam int GAIN_LIMIT   = 15;
    localparam int INPUT_COUNT  = 4;
    localparam int PERCENT_MAX  = 100;

    // Constant last byte of every frame
    localparam logic [7:0] FRAME_TAIL = 8'h0C;

    // Configuration register indexes (paddr[2])
    localparam logic REG_DEVICE_ADDRESS = 1'b0;

    // Percent to attenuation: floor*v/100 as one multiply by a reciprocal.
    localparam int          PCT_SHIFT = 19;
    localparam logic [26:0] PCT_MUL   = 27'(VOLUME_FLOOR * 5243);

    // Attenuation to percent: 100*a/floor as one multiply by a reciprocal.
    localparam int          ATT_SHIFT = 24;
    localparam logic [26:0] ATT_MUL   = 27'(PERCENT_MAX * ((1 << ATT_SHIFT) / VOLUME_FLOOR + 1));

    typedef enum logic [4:0] {
        ACT_SET_INPUT   = 5'd0,
        ACT_NEXT_INPUT  = 5'd1,
        ACT_PREV_INPUT  = 5'd2,
        ACT_SET_VOL     = 5'd3,
        ACT_VOL_DB      = 5'd4,
        ACT_VOL_PERCENT = 5'd5,
        ACT_VOL_UP      = 5'd6,
        ACT_VOL_DOWN    = 5'd7,
        ACT_VOL_UP_EXP  = 5'd8,
        ACT_VOL_DN_EXP  = 5'd9,
        ACT_MUTE        = 5'd10,
        ACT_UNMUTE      = 5'd11,
        ACT_MUTE_TOGGLE = 5'd12,
        ACT_GAIN        = 5'd13,
        ACT_GAIN_DB     = 5'd14,
        ACT_GAIN_UP     = 5'd15,
        ACT_GAIN_DOWN   = 5'd16,
        ACT_TREBLE      = 5'd17,
        ACT_TREBLE_DB   = 5'd18,
        ACT_TREBLE_UP   = 5'd19,
        ACT_TREBLE_DOWN = 5'd20,
        ACT_BASS        = 5'd21,
        ACT_BASS_DB     = 5'd22,
        ACT_BASS_UP     = 5'd23,
        ACT_BASS_DOWN   = 5'd24,
        ACT_RESET_EQ    = 5'd25
    } action_t;

    // Exponential step factor {1,1,1,2,2,4,8,8,16} indexed by atten/10,
    // returned as a shift amount; the last entry serves every index past it.
    function automatic logic [2:0] exp_shift(input logic [6:0] atten);
        logic [2:0] sh;
        if (atten >= 7'd80) begin
            sh = 3'd4;
        end else if (atten >= 7'd60) begin
            sh = 3'd3;
        end else if (atten >= 7'd50) begin
            sh = 3'd2;
        end else if (atten >= 7'd30) begin
            sh = 3'd1;
        end else begin
            sh = 3'd0;
        end
        return sh;
    endfunction

endpackage

// ===== hdl/audio_volume_tone_controller_core.sv =====
// Audio volume and tone controller: command decoder and register image, one module.
// Depends on avtc_pkg. A result is registered and appears in the cycle after its command
// transaction. Takes one command per cycle while the result channel is not stalled.
// Reset (aresetn low, synchronous): image cleared, saved level at the floor (not muted),
// device address 0, no result pending.
`timescale 1ns / 1ps

module audio_volume_tone_controller_core (
    input  logic        aclk,
    input  logic        aresetn,
    // command channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_action,
    input  logic signed [8:0] s_value,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic        m_frame_sent,
    output logic [31:0] m_frame_data,
    output logic [1:0]  m_input_select,
    output logic [6:0]  m_volume_atten,
    output logic [6:0]  m_volume_percent,
    output logic        m_muted,
    output logic [3:0]  m_gain_step,
    output logic signed [3:0] m_treble_step,
    output logic [3:0]  m_bass_step,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import avtc_pkg::*;

    localparam logic [6:0] FLOOR7 = 7'(VOLUME_FLOOR);

    // Register image and saved pre-mute level
    logic [1:0] input_reg,  input_next;
    logic [3:0] gain_reg,   gain_next;
    logic [6:0] atten_reg,  atten_next;
    logic [3:0] treble_reg, treble_next;   // sign-magnitude, bit 3 is the sign
    logic [3:0] bass_reg,   bass_next;
    logic [6:0] saved_reg,  saved_next;
    logic [7:0] dev_addr_reg;

    // Result register: the image fields are read straight from the image,
    // which only moves when a new result is loaded.
    logic m_valid_reg;
    logic ok_reg, ok_next;
    logic sent_reg, sent_next;

    logic    accept;
    action_t act;

    logic               muted_now;
    logic signed [14:0] atten_s;
    logic signed [14:0] step;
    logic signed [14:0] vol_t;
    logic signed [9:0]  v_ext;
    logic signed [9:0]  v_half;
    logic signed [9:0]  lvl;        // candidate for gain, bass or treble
    logic signed [4:0]  treble_now;
    logic [26:0]        pct_prod;
    logic [33:0]        readback_prod;

    // ------------------------------------------------------------------
    // Handshake: take a new command whenever the result slot is empty or
    // its transaction completes in this cycle.
    // ------------------------------------------------------------------
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    assign act = action_t'(s_action);

    // ------------------------------------------------------------------
    // Shared operands
    // ------------------------------------------------------------------
    assign muted_now  = saved_reg < FLOOR7;
    assign atten_s    = $signed({8'd0, atten_reg});
    assign treble_now = treble_reg[3] ? -$signed({2'b00, treble_reg[2:0]})
                                      :  $signed({2'b00, treble_reg[2:0]});
    assign v_ext      = 10'(s_value);
    // halve toward zero, as a signed divide by two would
    assign v_half     = (v_ext + (s_value[8] ? 10'sd1 : 10'sd0)) >>> 1;
    // percent form: floor - floor*v/100, valid for v in 0..100
    assign pct_prod   = 27'(s_value[6:0]) * PCT_MUL;

    // Step size: plain operand, or operand scaled by the exponential factor
    always_comb begin
        if (act == ACT_VOL_UP_EXP || act == ACT_VOL_DN_EXP) begin
            step = 15'(s_value) <<< exp_shift(atten_reg);
        end else begin
            step = 15'(s_value);
        end
    end

    // ------------------------------------------------------------------
    // Command decode and image update
    // ------------------------------------------------------------------
    always_comb begin
        input_next  = input_reg;
        gain_next   = gain_reg;
        atten_next  = atten_reg;
        treble_next = treble_reg;
        bass_next   = bass_reg;
        saved_next  = saved_reg;
        ok_next     = 1'b0;
        vol_t       = atten_s;
        lvl         = v_ext;

        unique case (act)
            ACT_SET_INPUT: begin
                if (s_value >= 0 && s_value <= 9'(INPUT_COUNT - 1)) begin
                    input_next = s_value[1:0];
                    ok_next    = 1'b1;
                end
            end
            ACT_NEXT_INPUT: begin
                input_next = (32'(input_reg) + 1 > INPUT_COUNT - 1) ? 2'd0 : input_reg + 2'd1;
                ok_next    = 1'b1;
            end
            ACT_PREV_INPUT: begin
                input_next = (input_reg == 2'd0) ? 2'(INPUT_COUNT - 1) : input_reg - 2'd1;
                ok_next    = 1'b1;
            end
            ACT_SET_VOL, ACT_VOL_DB: begin
                vol_t = (act == ACT_SET_VOL) ? 15'(s_value) : -15'(s_value);
                if (vol_t >= 0 && vol_t <= 15'(VOLUME_FLOOR)) begin
                    atten_next = vol_t[6:0];
                    ok_next    = 1'b1;
                end
            end
            ACT_VOL_PERCENT: begin
                if (s_value >= 0 && s_value <= 9'(PERCENT_MAX)) begin
                    atten_next = FLOOR7 - 7'(pct_prod >> PCT_SHIFT);
                    ok_next    = 1'b1;
                end
            end
            ACT_VOL_UP, ACT_VOL_UP_EXP: begin
                // undo a mute first; that alone is the whole command
                if (muted_now) begin
                    atten_next = saved_reg;
                    saved_next = FLOOR7;
                    ok_next    = 1'b1;
                end else if (atten_reg != 7'd0) begin
                    vol_t = atten_s - step;
                    if (vol_t <= 0) begin
                        vol_t = '0;
                    end
                    if (vol_t <= 15'(VOLUME_FLOOR)) begin
                        atten_next = vol_t[6:0];
                        ok_next    = 1'b1;
                    end
                end
            end
            ACT_VOL_DOWN, ACT_VOL_DN_EXP: begin
                if (muted_now) begin
                    atten_next = saved_reg;
                    saved_next = FLOOR7;
                    ok_next    = 1'b1;
                end else if (atten_reg < FLOOR7) begin
                    vol_t = atten_s + step;
                    if (vol_t >= 15'(VOLUME_FLOOR)) begin
                        vol_t = 15'(VOLUME_FLOOR);
                    end
                    if (vol_t >= 0) begin
                        atten_next = vol_t[6:0];
                        ok_next    = 1'b1;
                    end
                end
            end
            ACT_MUTE: begin
                if (atten_reg < FLOOR7) begin
                    saved_next = atten_reg;
                    atten_next = FLOOR7;
                    ok_next    = 1'b1;
                end
            end
            ACT_UNMUTE: begin
                if (muted_now) begin
                    atten_next = saved_reg;
                    saved_next = FLOOR7;
                    ok_next    = 1'b1;
                end
            end
            ACT_MUTE_TOGGLE: begin
                if (muted_now) begin
                    atten_next = saved_reg;
                    saved_next = FLOOR7;
                    ok_next    = 1'b1;
                end else if (atten_reg < FLOOR7) begin
                    saved_next = atten_reg;
                    atten_next = FLOOR7;
                    ok_next    = 1'b1;
                end
            end
            ACT_GAIN, ACT_GAIN_DB, ACT_GAIN_UP, ACT_GAIN_DOWN: begin
                case (act)
                    ACT_GAIN_DB:   lvl = v_half;
                    ACT_GAIN_UP:   lvl = $signed({6'd0, gain_reg}) + 10'sd1;
                    ACT_GAIN_DOWN: lvl = $signed({6'd0, gain_reg}) - 10'sd1;
                    default:       lvl = v_ext;
                endcase
                // negative dB requests are refused outright
                if (!(act == ACT_GAIN_DB && s_value < 0) &&
                    lvl >= 0 && lvl <= 10'(GAIN_LIMIT)) begin
                    gain_next = lvl[3:0];
                    ok_next   = 1'b1;
                end
            end
            ACT_BASS, ACT_BASS_DB, ACT_BASS_UP, ACT_BASS_DOWN: begin
                case (act)
                    ACT_BASS_DB:   lvl = v_half;
                    ACT_BASS_UP:   lvl = $signed({6'd0, bass_reg}) + 10'sd1;
                    ACT_BASS_DOWN: lvl = $signed({6'd0, bass_reg}) - 10'sd1;
                    default:       lvl = v_ext;
                endcase
                if (!(act == ACT_BASS_DB && s_value < 0) &&
                    lvl >= 0 && lvl <= 10'(BASS_LIMIT)) begin
                    bass_next = lvl[3:0];
                    ok_next   = 1'b1;
                end
            end
            ACT_TREBLE, ACT_TREBLE_DB, ACT_TREBLE_UP, ACT_TREBLE_DOWN: begin
                case (act)
                    ACT_TREBLE_DB:   lvl = v_half;
                    ACT_TREBLE_UP:   lvl = 10'(treble_now) + 10'sd1;
                    ACT_TREBLE_DOWN: lvl = 10'(treble_now) - 10'sd1;
                    default:         lvl = v_ext;
                endcase
                if (lvl >= -10'(TREBLE_LIMIT) && lvl <= 10'(TREBLE_LIMIT)) begin
                    // encode as sign and magnitude
                    if (lvl < 0) begin
                        treble_next = {1'b1, 3'(-lvl)};
                    end else begin
                        treble_next = {1'b0, lvl[2:0]};
                    end
                    ok_next = 1'b1;
                end
            end
            ACT_RESET_EQ: begin
                gain_next   = '0;
                treble_next = '0;
                bass_next   = '0;
                ok_next     = 1'b1;
            end
            default: begin
                // unknown command: refuse and hold the image
                ok_next = 1'b0;
            end
        endcase

        // a frame goes out whenever any byte of the image moves
        sent_next = (input_next != input_reg) || (gain_next != gain_reg) ||
                    (atten_next != atten_reg) || (treble_next != treble_reg) ||
                    (bass_next != bass_reg);
    end

    // ------------------------------------------------------------------
    // Image and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_reg   <= '0;
            gain_reg    <= '0;
            atten_reg   <= '0;
            treble_reg  <= '0;
            bass_reg    <= '0;
            saved_reg   <= FLOOR7;
            m_valid_reg <= 1'b0;
            ok_reg      <= 1'b0;
            sent_reg    <= 1'b0;
        end else begin
            if (accept) begin
                input_reg   <= input_next;
                gain_reg    <= gain_next;
                atten_reg   <= atten_next;
                treble_reg  <= treble_next;
                bass_reg    <= bass_next;
                saved_reg   <= saved_next;
                ok_reg      <= ok_next;
                sent_reg    <= sent_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                // drop the result once its transaction completes
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result fields
    // ------------------------------------------------------------------
    assign m_ok           = ok_reg;
    assign m_frame_sent   = sent_reg;
    assign m_frame_data   = {FRAME_TAIL, bass_reg, treble_reg, 1'b0, atten_reg,
                             gain_reg, 2'b00, input_reg};
    assign m_input_select = input_reg;
    assign m_volume_atten = atten_reg;
    assign m_muted        = muted_now;
    assign m_gain_step    = gain_reg;
    assign m_treble_step  = treble_now[3:0];
    assign m_bass_step    = bass_reg;

    // percent readback: 100 - 100*atten/floor, truncated
    assign readback_prod    = 34'(atten_reg) * 34'(ATT_MUL);
    assign m_volume_percent = 7'(PERCENT_MAX) - 7'(readback_prod >> ATT_SHIFT);

    // ------------------------------------------------------------------
    // Configuration port: the bus address is held but shapes no result
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= '0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_DEVICE_ADDRESS) begin
            dev_addr_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_DEVICE_ADDRESS) ? {24'd0, dev_addr_reg} : 32'd0;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_atten_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        atten_reg <= FLOOR7 && saved_reg <= FLOOR7)
        else $error("attenuation or saved level above the floor");

    a_input_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(input_reg) < INPUT_COUNT)
        else $error("input select outside the input count");

    a_treble_code: assert property (@(posedge aclk) disable iff (!aresetn)
        !(treble_reg[3] && treble_reg[2:0] == 3'd0) &&
        32'(treble_reg[2:0]) <= TREBLE_LIMIT)
        else $error("treble code is negative zero or past its limit");

    a_refused_no_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> !m_frame_sent)
        else $error("refused command changed the image");

    a_image_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(m_frame_data) && $stable(saved_reg))
        else $error("image moved without a command transaction");

endmodule

// ===== dv/tb_audio_volume_tone_controller_core.sv =====
// Self-checking testbench for audio_volume_tone_controller_core: drives command
// transactions and device address writes, and checks every result against a predictor.
// Depends on avtc_pkg and the core; stands alone otherwise.
`timescale 1ns / 1ps

module tb_audio_volume_tone_controller_core;
    import avtc_pkg::*;

    localparam int          CLK_HALF         = 4;
    localparam int          RANDOM_PER_PHASE = 390;
    localparam int          PHASE_COUNT      = 5;
    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int          IDLE_PERCENT     = 18;
    localparam int          EXP_LAST         = 8;
    localparam logic [4:0]  ACT_CODE_LAST    = 5'd31;
    localparam logic [2:0]  DEVADDR_OFFSET   = {REG_DEVICE_ADDRESS, 2'b00};

    localparam int          EXP_FACTOR [0:EXP_LAST] = '{1, 1, 1, 2, 2, 4, 8, 8, 16};
    localparam int          VALUE_EDGES [0:7]       = '{0, -1, 255, -256, 80, 81, 100, 101};
    localparam logic [7:0]  PHASE_ADDR [0:3]        = '{8'h00, 8'hA5, 8'h5A, 8'h81};

    typedef struct {
        logic              ok;
        logic              frame_sent;
        logic [31:0]       frame_data;
        logic [1:0]        input_select;
        logic [6:0]        volume_atten;
        logic [6:0]        volume_percent;
        logic              muted;
        logic [3:0]        gain_step;
        logic signed [3:0] treble_step;
        logic [3:0]        bass_step;
    } tone_result_t;

    // Register image predictor and the queue of results still owed by the core.
    class tone_image_scoreboard;
        int           sel_input;
        int           gain;
        int           atten;
        int           treble;
        int           bass;
        int           saved_atten;
        logic [7:0]   dev_addr;
        tone_result_t due_q[$];
        int unsigned  mismatches;
        int unsigned  commands;
        int unsigned  checked;
        int unsigned  rejected;
        int unsigned  frames;
        int unsigned  muted_results;

        function new();
            sel_input   = 0;
            gain        = 0;
            atten       = 0;
            treble      = 0;
            bass        = 0;
            saved_atten = VOLUME_FLOOR;
            dev_addr    = 8'h00;
        endfunction

        function logic [31:0] frame_word();
            logic [3:0] code;
            // treble goes out as sign-magnitude, sign in bit 3
            code = (treble < 0) ? 4'(8 - treble) : 4'(treble);
            return {FRAME_TAIL, 4'(bass), code, 1'b0, 7'(atten), 4'(gain), 2'b00,
                    2'(sel_input)};
        endfunction

        function bit put_input(int v);
            if (v < 0 || v > INPUT_COUNT - 1) return 1'b0;
            sel_input = v;
            return 1'b1;
        endfunction

        function bit put_atten(int v);
            if (v < 0 || v > VOLUME_FLOOR) return 1'b0;
            atten = v;
            return 1'b1;
        endfunction

        function bit put_gain(int v);
            if (v < 0 || v > GAIN_LIMIT) return 1'b0;
            gain = v;
            return 1'b1;
        endfunction

        function bit put_bass(int v);
            if (v < 0 || v > BASS_LIMIT) return 1'b0;
            bass = v;
            return 1'b1;
        endfunction

        function bit put_treble(int v);
            if (v < -TREBLE_LIMIT || v > TREBLE_LIMIT) return 1'b0;
            treble = v;
            return 1'b1;
        endfunction

        function bit unmute();
            if (saved_atten >= VOLUME_FLOOR) return 1'b0;
            atten       = saved_atten;
            saved_atten = VOLUME_FLOOR;
            return 1'b1;
        endfunction

        function bit mute();
            if (atten >= VOLUME_FLOOR) return 1'b0;
            saved_atten = atten;
            atten       = VOLUME_FLOOR;
            return 1'b1;
        endfunction

        // A pending mute is undone first, and that alone counts as success.
        function bit vol_up(int step);
            int t;
            if (unmute()) return 1'b1;
            if (atten == 0) return 1'b0;
            t = atten - step;
            if (t <= 0) t = 0;
            return put_atten(t);
        endfunction

        function bit vol_down(int step);
            int t;
            if (unmute()) return 1'b1;
            if (atten >= VOLUME_FLOOR) return 1'b0;
            t = atten + step;
            if (t >= VOLUME_FLOOR) t = VOLUME_FLOOR;
            return put_atten(t);
        endfunction

        function void note_command(logic [4:0] act, logic signed [8:0] val);
            int           v;
            int           idx;
            int           exp_step;
            bit           ok;
            logic [31:0]  prior;
            tone_result_t r;
            v   = val;
            // the exponential factor is taken from the level before any unmute
            idx = atten / 10;
            if (idx > EXP_LAST) idx = EXP_LAST;
            exp_step = EXP_FACTOR[idx] * v;
            prior    = frame_word();
            ok       = 1'b0;
            case (act)
                ACT_SET_INPUT:   ok = put_input(v);
                ACT_NEXT_INPUT:  ok = put_input(sel_input + 1 > INPUT_COUNT - 1 ? 0
                                                : sel_input + 1);
                ACT_PREV_INPUT:  ok = put_input(sel_input == 0 ? INPUT_COUNT - 1
                                                : sel_input - 1);
                ACT_SET_VOL:     ok = put_atten(v);
                ACT_VOL_DB:      ok = put_atten(-v);
                ACT_VOL_PERCENT: begin
                    if (v >= 0 && v <= PERCENT_MAX)
                        ok = put_atten(VOLUME_FLOOR - (VOLUME_FLOOR * v) / PERCENT_MAX);
                end
                ACT_VOL_UP:      ok = vol_up(v);
                ACT_VOL_DOWN:    ok = vol_down(v);
                ACT_VOL_UP_EXP:  ok = vol_up(exp_step);
                ACT_VOL_DN_EXP:  ok = vol_down(exp_step);
                ACT_MUTE:        ok = mute();
                ACT_UNMUTE:      ok = unmute();
                ACT_MUTE_TOGGLE: begin
                    ok = unmute();
                    if (!ok) ok = mute();
                end
                ACT_GAIN:        ok = put_gain(v);
                ACT_GAIN_DB: begin
                    if (v >= 0) ok = put_gain(v / 2);
                end
                ACT_GAIN_UP:     ok = put_gain(gain + 1);
                ACT_GAIN_DOWN:   ok = put_gain(gain - 1);
                ACT_TREBLE:      ok = put_treble(v);
                ACT_TREBLE_DB:   ok = put_treble(v / 2);
                ACT_TREBLE_UP:   ok = put_treble(treble + 1);
                ACT_TREBLE_DOWN: ok = put_treble(treble - 1);
                ACT_BASS:        ok = put_bass(v);
                ACT_BASS_DB: begin
                    if (v >= 0) ok = put_bass(v / 2);
                end
                ACT_BASS_UP:     ok = put_bass(bass + 1);
                ACT_BASS_DOWN:   ok = put_bass(bass - 1);
                ACT_RESET_EQ: begin
                    gain   = 0;
                    treble = 0;
                    bass   = 0;
                    ok     = 1'b1;
                end
                default:         ok = 1'b0;
            endcase
            r.ok             = ok;
            r.frame_data     = frame_word();
            r.frame_sent     = (r.frame_data != prior);
            r.input_select   = 2'(sel_input);
            r.volume_atten   = 7'(atten);
            r.volume_percent = 7'(PERCENT_MAX - (PERCENT_MAX * atten) / VOLUME_FLOOR);
            r.muted          = (saved_atten < VOLUME_FLOOR);
            r.gain_step      = 4'(gain);
            r.treble_step    = 4'(treble);
            r.bass_step      = 4'(bass);
            due_q.push_back(r);
            commands++;
            if (!r.ok) rejected++;
            if (r.frame_sent) frames++;
            if (r.muted) muted_results++;
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(tone_result_t got);
            tone_result_t want;
            if (due_q.size() == 0) begin
                $error("result transaction with no command outstanding");
                mismatches++;
                return;
            end
            want = due_q.pop_front();
            checked++;
            compare_field("ok", want.ok, got.ok);
            compare_field("frame_sent", want.frame_sent, got.frame_sent);
            compare_field("frame_data", want.frame_data, got.frame_data);
            compare_field("input_select", want.input_select, got.input_select);
            compare_field("volume_atten", want.volume_atten, got.volume_atten);
            compare_field("volume_percent", want.volume_percent, got.volume_percent);
            compare_field("muted", want.muted, got.muted);
            compare_field("gain_step", want.gain_step, got.gain_step);
            compare_field("treble_step", want.treble_step, got.treble_step);
            compare_field("bass_step", want.bass_step, got.bass_step);
        endfunction
    endclass

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [4:0]        s_action = '0;
    logic signed [8:0] s_value  = '0;
    logic              m_valid;
    logic              m_ready  = 1'b0;
    logic              m_ok;
    logic              m_frame_sent;
    logic [31:0]       m_frame_data;
    logic [1:0]        m_input_select;
    logic [6:0]        m_volume_atten;
    logic [6:0]        m_volume_percent;
    logic              m_muted;
    logic [3:0]        m_gain_step;
    logic signed [3:0] m_treble_step;
    logic [3:0]        m_bass_step;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [2:0]        paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    tone_image_scoreboard sb = new();
    tone_result_t         seen_result;
    bit                   idle_on     = 1'b1;
    int unsigned          cycle_count = 0;

    audio_volume_tone_controller_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_frame_sent     (m_frame_sent),
        .m_frame_data     (m_frame_data),
        .m_input_select   (m_input_select),
        .m_volume_atten   (m_volume_atten),
        .m_volume_percent (m_volume_percent),
        .m_muted          (m_muted),
        .m_gain_step      (m_gain_step),
        .m_treble_step    (m_treble_step),
        .m_bass_step      (m_bass_step),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Sample the result channel at the edge, then pick the next stall state.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_result.ok             = m_ok;
            seen_result.frame_sent     = m_frame_sent;
            seen_result.frame_data     = m_frame_data;
            seen_result.input_select   = m_input_select;
            seen_result.volume_atten   = m_volume_atten;
            seen_result.volume_percent = m_volume_percent;
            seen_result.muted          = m_muted;
            seen_result.gain_step      = m_gain_step;
            seen_result.treble_step    = m_treble_step;
            seen_result.bass_step      = m_bass_step;
            sb.check_result(seen_result);
        end
        m_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $error("run exceeded %0d cycles", CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Hold valid and payload until the transaction is taken, then note it.
    task automatic send_cmd(input logic [4:0] act, input int val);
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_value  <= 9'(val);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_command(act, 9'(val));
    endtask

    // Write the device address, then read it back.
    task automatic write_device_address(input logic [7:0] addr_byte);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DEVADDR_OFFSET;
        pwdata  <= {24'd0, addr_byte};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.dev_addr = addr_byte;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== {24'd0, sb.dev_addr}) begin
            $error("device_address: expected 0x%0h, actual 0x%0h", sb.dev_addr, prdata);
            sb.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop valid and let every owed result come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.due_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Bias towards the volume and mute commands, where the state is deepest.
    function automatic logic [4:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 5'($urandom_range(ACT_RESET_EQ + 1, ACT_CODE_LAST));
        if (r < 40) return 5'($urandom_range(ACT_SET_VOL, ACT_MUTE_TOGGLE));
        return 5'($urandom_range(ACT_SET_INPUT, ACT_RESET_EQ));
    endfunction

    function automatic int pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom_range(0, 12);
        if (r < 6) return int'($urandom_range(0, 200)) - 100;
        if (r < 8) return int'($urandom_range(0, 511)) - 256;
        if (r < 9) return VALUE_EDGES[$urandom_range(0, 7)];
        return $urandom_range(0, PERCENT_MAX);
    endfunction

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_device_address(8'hFF);

        // Directed pass: wraps, limits, rejects, mute handling, equaliser reset.
        send_cmd(ACT_SET_INPUT, 3);
        send_cmd(ACT_NEXT_INPUT, 0);
        send_cmd(ACT_PREV_INPUT, 0);
        send_cmd(ACT_SET_VOL, VOLUME_FLOOR + 1);
        send_cmd(ACT_VOL_DB, -40);
        send_cmd(ACT_VOL_PERCENT, PERCENT_MAX + 1);
        send_cmd(ACT_VOL_PERCENT, 0);
        send_cmd(ACT_VOL_UP_EXP, 1);
        send_cmd(ACT_MUTE, 0);
        send_cmd(ACT_VOL_DOWN, 5);
        send_cmd(ACT_MUTE_TOGGLE, 0);
        send_cmd(ACT_UNMUTE, 0);
        send_cmd(ACT_VOL_DN_EXP, 255);
        send_cmd(ACT_VOL_DOWN, 1);
        send_cmd(ACT_VOL_UP, -128);
        send_cmd(ACT_MUTE_TOGGLE, 0);
        send_cmd(ACT_GAIN, GAIN_LIMIT);
        send_cmd(ACT_GAIN_UP, 0);
        send_cmd(ACT_GAIN_DB, -2);
        send_cmd(ACT_GAIN_DOWN, 0);
        send_cmd(ACT_TREBLE, -TREBLE_LIMIT);
        send_cmd(ACT_TREBLE_DB, 11);
        send_cmd(ACT_TREBLE_UP, 0);
        send_cmd(ACT_BASS_DB, 21);
        send_cmd(ACT_BASS, BASS_LIMIT);
        send_cmd(ACT_BASS_UP, 0);
        send_cmd(ACT_BASS_DOWN, 0);
        send_cmd(ACT_RESET_EQ, -256);
        send_cmd(ACT_CODE_LAST, 255);
        drain_results();

        // Random phases, a new device address each; the middle one runs flat out.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_device_address(p < 4 ? PHASE_ADDR[p] : 8'($urandom_range(0, 255)));
            idle_on = (p != 2);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_cmd(pick_action(), pick_value());
            end
            drain_results();
        end

        $display("Covered %0d commands (%0d rejected), %0d results checked",
                 sb.commands, sb.rejected, sb.checked);
        $display("Frames changed on %0d results, muted on %0d, %0d mismatches",
                 sb.frames, sb.muted_results, sb.mismatches);
        if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
